// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CPSR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpsr: same-cycle check failed");

// next-cycle implication
`define CPSR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpsr: next-cycle check failed");

`endif

// ----- rtl/core/cpsr_pkg.sv -----
`default_nettype none

package cpsr_pkg;

  localparam int FIELD_W = 16;
  localparam int K_W = $clog2(FIELD_W);
  localparam int PC_W = 6;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [PC_W-1:0] pc_t;

  localparam logic [1:0] REG_COEF_A = 2'd0;
  localparam logic [1:0] REG_COEF_B = 2'd1;
  localparam logic [1:0] REG_PRIME_P = 2'd2;

  typedef struct packed {
    logic   start;
    field_t a;
    field_t b;
  } mul_req_t;

  typedef struct packed {
    logic   done;
    logic   busy;
    field_t prod;
  } mul_rsp_t;

  typedef enum logic {
    MUL_IDLE,
    MUL_RUN
  } mul_state_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_STEP,
    SEQ_WAIT
  } seq_state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL,
    OP_ADD,
    OP_MOV,
    OP_LDE,
    OP_DECK,
    OP_FIN_ROOT,
    OP_FIN_ZERO,
    OP_FIN_NONE,
    OP_FIN_FAIL
  } op_t;

  typedef enum logic [2:0] {
    RG_X,
    RG_G,
    RG_T,
    RG_C,
    RG_ACC,
    RG_BASE,
    RG_Y,
    RG_Z
  } reg_sel_t;

  typedef enum logic [3:0] {
    SR_X,
    SR_G,
    SR_T,
    SR_C,
    SR_ACC,
    SR_BASE,
    SR_Y,
    SR_Z,
    SR_ONE,
    SR_XIN,
    SR_COEF_A,
    SR_COEF_B,
    SR_EXP3,
    SR_EXP5Z,
    SR_EXP5U,
    SR_EXP5V
  } src_sel_t;

  typedef enum logic [3:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_UNSUP,
    JC_GZERO,
    JC_MODE5,
    JC_NEBIT,
    JC_KNZ,
    JC_TEQG,
    JC_ZONE,
    JC_NZNEG
  } jcond_t;

  typedef struct packed {
    op_t      op;
    reg_sel_t dst;
    src_sel_t src_a;
    src_sel_t src_b;
    jcond_t   jc;
    pc_t      target;
  } ucode_t;

  // program labels
  localparam pc_t L_START = 6'd0;
  localparam pc_t L_SQ3 = 6'd13;
  localparam pc_t L_DEC3 = 6'd16;
  localparam pc_t L_NONE = 6'd20;
  localparam pc_t L_MODE5 = 6'd21;
  localparam pc_t L_SQZ = 6'd23;
  localparam pc_t L_DECZ = 6'd26;
  localparam pc_t L_SQV = 6'd34;
  localparam pc_t L_DECV = 6'd37;
  localparam pc_t L_5A = 6'd40;
  localparam pc_t L_SQU = 6'd41;
  localparam pc_t L_DECU = 6'd44;
  localparam pc_t L_ROOT = 6'd46;
  localparam pc_t L_ZERO = 6'd47;
  localparam pc_t L_FAIL = 6'd48;

  function automatic ucode_t uw(op_t op, reg_sel_t dst, src_sel_t a, src_sel_t b,
                                jcond_t jc, pc_t tgt);
    ucode_t w;
    w.op = op;
    w.dst = dst;
    w.src_a = a;
    w.src_b = b;
    w.jc = jc;
    w.target = tgt;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    unique case (pc)
      6'd0:  w = uw(OP_NOP, RG_X, SR_ONE, SR_ONE, JC_UNSUP, L_FAIL);
      6'd1:  w = uw(OP_MUL, RG_X, SR_ONE, SR_XIN, JC_NEVER, L_START);
      6'd2:  w = uw(OP_MUL, RG_T, SR_X, SR_X, JC_NEVER, L_START);
      6'd3:  w = uw(OP_MUL, RG_T, SR_T, SR_X, JC_NEVER, L_START);
      6'd4:  w = uw(OP_MUL, RG_C, SR_ONE, SR_COEF_A, JC_NEVER, L_START);
      6'd5:  w = uw(OP_MUL, RG_C, SR_C, SR_X, JC_NEVER, L_START);
      6'd6:  w = uw(OP_ADD, RG_T, SR_T, SR_C, JC_NEVER, L_START);
      6'd7:  w = uw(OP_MUL, RG_C, SR_ONE, SR_COEF_B, JC_NEVER, L_START);
      6'd8:  w = uw(OP_ADD, RG_G, SR_T, SR_C, JC_NEVER, L_START);
      6'd9:  w = uw(OP_NOP, RG_X, SR_ONE, SR_ONE, JC_GZERO, L_ZERO);
      6'd10: w = uw(OP_NOP, RG_X, SR_ONE, SR_ONE, JC_MODE5, L_MODE5);
      // p = 3 mod 4
      6'd11: w = uw(OP_MOV, RG_BASE, SR_G, SR_ONE, JC_NEVER, L_START);
      6'd12: w = uw(OP_LDE, RG_ACC, SR_EXP3, SR_ONE, JC_NEVER, L_START);
      6'd13: w = uw(OP_MUL, RG_ACC, SR_ACC, SR_ACC, JC_NEVER, L_START);
      6'd14: w = uw(OP_NOP, RG_X, SR_ONE, SR_ONE, JC_NEBIT, L_DEC3);
      6'd15: w = uw(OP_MUL, RG_ACC, SR_BASE, SR_ACC, JC_NEVER, L_START);
      6'd16: w = uw(OP_DECK, RG_X, SR_ONE, SR_ONE, JC_KNZ, L_SQ3);
      6'd17: w = uw(OP_MOV, RG_Y, SR_ACC, SR_ONE, JC_NEVER, L_START);
      6'd18: w = uw(OP_MUL, RG_T, SR_Y, SR_Y, JC_NEVER, L_START);
      6'd19: w = uw(OP_NOP, RG_X, SR_ONE, SR_ONE, JC_TEQG, L_ROOT);
      6'd20: w = uw(OP_FIN_NONE, RG_X, SR_ONE, SR_ONE, JC_NEVER, L_START);
      // p = 5 mod 8
      6'd21: w = uw(OP_MOV, RG_BASE, SR_G, SR_ONE, JC_NEVER, L_START);
      6'd22: w = uw(OP_LDE, RG_ACC, SR_EXP5Z, SR_ONE, JC_NEVER, L_START);
      6'd23: w = uw(OP_MUL, RG_ACC, SR_ACC, SR_ACC, JC_NEVER, L_START);
      6'd24: w = uw(OP_NOP, RG_X, SR_ONE, SR_ONE, JC_NEBIT, L_DECZ);
      6'd25: w = uw(OP_MUL, RG_ACC, SR_BASE, SR_ACC, JC_NEVER, L_START);
      6'd26: w = uw(OP_DECK, RG_X, SR_ONE, SR_ONE, JC_KNZ, L_SQZ);
      6'd27: w = uw(OP_MOV, RG_Z, SR_ACC, SR_ONE, JC_NEVER, L_START);
      6'd28: w = uw(OP_NOP, RG_X, SR_ONE, SR_ONE, JC_ZONE, L_5A);
      6'd29: w = uw(OP_NOP, RG_X, SR_ONE, SR_ONE, JC_NZNEG, L_NONE);
      6'd30: w = uw(OP_ADD, RG_T, SR_G, SR_G, JC_NEVER, L_START);
      6'd31: w = uw(OP_ADD, RG_C, SR_T, SR_T, JC_NEVER, L_START);
      6'd32: w = uw(OP_MOV, RG_BASE, SR_C, SR_ONE, JC_NEVER, L_START);
      6'd33: w = uw(OP_LDE, RG_ACC, SR_EXP5V, SR_ONE, JC_NEVER, L_START);
      6'd34: w = uw(OP_MUL, RG_ACC, SR_ACC, SR_ACC, JC_NEVER, L_START);
      6'd35: w = uw(OP_NOP, RG_X, SR_ONE, SR_ONE, JC_NEBIT, L_DECV);
      6'd36: w = uw(OP_MUL, RG_ACC, SR_BASE, SR_ACC, JC_NEVER, L_START);
      6'd37: w = uw(OP_DECK, RG_X, SR_ONE, SR_ONE, JC_KNZ, L_SQV);
      6'd38: w = uw(OP_MUL, RG_Y, SR_T, SR_ACC, JC_NEVER, L_START);
      6'd39: w = uw(OP_NOP, RG_X, SR_ONE, SR_ONE, JC_ALWAYS, L_ROOT);
      6'd40: w = uw(OP_LDE, RG_ACC, SR_EXP5U, SR_ONE, JC_NEVER, L_START);
      6'd41: w = uw(OP_MUL, RG_ACC, SR_ACC, SR_ACC, JC_NEVER, L_START);
      6'd42: w = uw(OP_NOP, RG_X, SR_ONE, SR_ONE, JC_NEBIT, L_DECU);
      6'd43: w = uw(OP_MUL, RG_ACC, SR_BASE, SR_ACC, JC_NEVER, L_START);
      6'd44: w = uw(OP_DECK, RG_X, SR_ONE, SR_ONE, JC_KNZ, L_SQU);
      6'd45: w = uw(OP_MOV, RG_Y, SR_ACC, SR_ONE, JC_NEVER, L_START);
      6'd46: w = uw(OP_FIN_ROOT, RG_X, SR_ONE, SR_ONE, JC_NEVER, L_START);
      6'd47: w = uw(OP_FIN_ZERO, RG_X, SR_ONE, SR_ONE, JC_NEVER, L_START);
      6'd48: w = uw(OP_FIN_FAIL, RG_X, SR_ONE, SR_ONE, JC_NEVER, L_START);
      default: w = uw(OP_FIN_FAIL, RG_X, SR_ONE, SR_ONE, JC_NEVER, L_START);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cpsr_modmul.sv -----
`default_nettype none

module cpsr_modmul (
  input  wire               clk,
  input  wire               rst,
  input  wire cpsr_pkg::mul_req_t req,
  input  wire cpsr_pkg::field_t  modulus,
  output cpsr_pkg::mul_rsp_t rsp
);

  localparam int S_W = cpsr_pkg::FIELD_W + 2;

  cpsr_pkg::mul_state_t state;
  cpsr_pkg::mul_state_t state_next;
  logic [cpsr_pkg::K_W-1:0] cnt;
  cpsr_pkg::field_t acc;
  cpsr_pkg::field_t a_op;
  cpsr_pkg::field_t b_sh;
  logic done;
  logic trivial;

  logic [S_W-1:0] sum;
  logic [S_W-1:0] p1;
  logic [S_W-1:0] p2;
  logic [S_W-1:0] red;

  assign trivial = (req.b == cpsr_pkg::FIELD_W'(1));

  // one bit of b per cycle, msb first, result kept below p
  always_comb begin
    p1 = {2'b00, modulus};
    p2 = {1'b0, modulus, 1'b0};
    sum = {1'b0, acc, 1'b0} + (b_sh[cpsr_pkg::FIELD_W-1] ? {2'b00, a_op} : '0);
    if (sum >= p2) begin
      red = sum - p2;
    end else if (sum >= p1) begin
      red = sum - p1;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cpsr_pkg::MUL_IDLE: begin
        if (req.start && !trivial) begin
          state_next = cpsr_pkg::MUL_RUN;
        end
      end
      cpsr_pkg::MUL_RUN: begin
        if (cnt == '0) begin
          state_next = cpsr_pkg::MUL_IDLE;
        end
      end
      default: state_next = cpsr_pkg::MUL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpsr_pkg::MUL_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      if (state == cpsr_pkg::MUL_IDLE && req.start) begin
        done <= trivial;
      end else if (state == cpsr_pkg::MUL_RUN && cnt == '0) begin
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == cpsr_pkg::MUL_IDLE && req.start) begin
      a_op <= req.a;
      b_sh <= req.b;
      cnt <= cpsr_pkg::K_W'(cpsr_pkg::FIELD_W - 1);
      acc <= trivial ? req.a : '0;
    end else if (state == cpsr_pkg::MUL_RUN) begin
      acc <= red[cpsr_pkg::FIELD_W-1:0];
      b_sh <= {b_sh[cpsr_pkg::FIELD_W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.busy = (state == cpsr_pkg::MUL_RUN);
  assign rsp.prod = acc;

endmodule

`default_nettype wire

// ----- rtl/core/curve_point_square_root.sv -----
// an unsupported modulus leads straight from the input accept to a fail result; a nontrivial
// modular product is worked out in the bit-serial multiplier, while a product by one is
// loaded into the multiplier result without its shift loop
// throughput: one item at a time; the sequencer goes back to idle, ready for the next item, as the
// result enters the output register, and a full output register holds the program back
// reset (synchronous) sets coef_a = 0, coef_b = 0, prime_p = 7
`default_nettype none
`include "assert_macros.svh"

module curve_point_square_root (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [cpsr_pkg::ADDR_W-1:0]        paddr,
  input  wire  [cpsr_pkg::DATA_W-1:0]        pwdata,
  output logic [cpsr_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [cpsr_pkg::FIELD_W-1:0]       x_coord,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [1:0]                         root_count,
  output logic [cpsr_pkg::FIELD_W-1:0]       y_first,
  output logic [cpsr_pkg::FIELD_W-1:0]       y_second,
  output logic                               status
);

  cpsr_pkg::field_t coef_a;
  cpsr_pkg::field_t coef_b;
  cpsr_pkg::field_t prime_p;
  logic [1:0] reg_idx;
  logic cfg_wr;

  cpsr_pkg::seq_state_t state;
  cpsr_pkg::seq_state_t state_next;
  cpsr_pkg::pc_t pc;
  cpsr_pkg::pc_t pc_next;
  cpsr_pkg::ucode_t uc;

  cpsr_pkg::field_t x_hold;
  cpsr_pkg::field_t x_mod;
  cpsr_pkg::field_t rhs;
  cpsr_pkg::field_t tmp;
  cpsr_pkg::field_t aux;
  cpsr_pkg::field_t acc;
  cpsr_pkg::field_t base;
  cpsr_pkg::field_t root;
  cpsr_pkg::field_t zval;
  cpsr_pkg::field_t expo;
  logic [cpsr_pkg::K_W-1:0] bit_idx;

  cpsr_pkg::field_t opa;
  cpsr_pkg::field_t opb;
  cpsr_pkg::field_t add_res;
  logic [cpsr_pkg::FIELD_W:0] add_sum;
  logic mode3;
  logic mode5;
  logic jump;
  logic out_free;

  logic wr_en;
  cpsr_pkg::reg_sel_t wr_dst;
  cpsr_pkg::field_t wr_data;
  logic ld_e;
  logic dec_k;
  logic out_load;

  cpsr_pkg::mul_req_t mul_req;
  cpsr_pkg::mul_rsp_t mul_rsp;

  // config port
  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      cpsr_pkg::REG_COEF_A:  prdata = cpsr_pkg::DATA_W'(coef_a);
      cpsr_pkg::REG_COEF_B:  prdata = cpsr_pkg::DATA_W'(coef_b);
      cpsr_pkg::REG_PRIME_P: prdata = cpsr_pkg::DATA_W'(prime_p);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= '0;
      coef_b <= '0;
      prime_p <= cpsr_pkg::FIELD_W'(7);
    end else if (cfg_wr) begin
      if (reg_idx == cpsr_pkg::REG_COEF_A) begin
        coef_a <= pwdata[cpsr_pkg::FIELD_W-1:0];
      end else if (reg_idx == cpsr_pkg::REG_COEF_B) begin
        coef_b <= pwdata[cpsr_pkg::FIELD_W-1:0];
      end else if (reg_idx == cpsr_pkg::REG_PRIME_P) begin
        prime_p <= pwdata[cpsr_pkg::FIELD_W-1:0];
      end
    end
  end

  // sequencer
  assign uc = cpsr_pkg::ucode_rom(pc);
  assign mode3 = (prime_p[1:0] == 2'b11);
  assign mode5 = (prime_p[2:0] == 3'b101);
  assign in_ready = (state == cpsr_pkg::SEQ_IDLE);
  assign out_free = !out_valid || out_ready;

  function automatic cpsr_pkg::field_t pick(cpsr_pkg::src_sel_t s, cpsr_pkg::field_t xm,
      cpsr_pkg::field_t g, cpsr_pkg::field_t t, cpsr_pkg::field_t c, cpsr_pkg::field_t ac,
      cpsr_pkg::field_t bs, cpsr_pkg::field_t y, cpsr_pkg::field_t z, cpsr_pkg::field_t xi,
      cpsr_pkg::field_t ca, cpsr_pkg::field_t cb, cpsr_pkg::field_t p);
    cpsr_pkg::field_t v;
    unique case (s)
      cpsr_pkg::SR_X:       v = xm;
      cpsr_pkg::SR_G:       v = g;
      cpsr_pkg::SR_T:       v = t;
      cpsr_pkg::SR_C:       v = c;
      cpsr_pkg::SR_ACC:     v = ac;
      cpsr_pkg::SR_BASE:    v = bs;
      cpsr_pkg::SR_Y:       v = y;
      cpsr_pkg::SR_Z:       v = z;
      cpsr_pkg::SR_ONE:     v = cpsr_pkg::FIELD_W'(1);
      cpsr_pkg::SR_XIN:     v = xi;
      cpsr_pkg::SR_COEF_A:  v = ca;
      cpsr_pkg::SR_COEF_B:  v = cb;
      cpsr_pkg::SR_EXP3:    v = (p >> 2) + cpsr_pkg::FIELD_W'(1);
      cpsr_pkg::SR_EXP5Z:   v = {2'b00, p[cpsr_pkg::FIELD_W-1:3], 1'b1};
      cpsr_pkg::SR_EXP5U:   v = (p >> 3) + cpsr_pkg::FIELD_W'(1);
      cpsr_pkg::SR_EXP5V:   v = p >> 3;
      default:              v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = pick(uc.src_a, x_mod, rhs, tmp, aux, acc, base, root, zval, x_hold,
               coef_a, coef_b, prime_p);
    opb = pick(uc.src_b, x_mod, rhs, tmp, aux, acc, base, root, zval, x_hold,
               coef_a, coef_b, prime_p);
    add_sum = {1'b0, opa} + {1'b0, opb};
    if (add_sum >= {1'b0, prime_p}) begin
      add_res = cpsr_pkg::FIELD_W'(add_sum - {1'b0, prime_p});
    end else begin
      add_res = add_sum[cpsr_pkg::FIELD_W-1:0];
    end
  end

  always_comb begin
    unique case (uc.jc)
      cpsr_pkg::JC_NEVER:  jump = 1'b0;
      cpsr_pkg::JC_ALWAYS: jump = 1'b1;
      cpsr_pkg::JC_UNSUP:  jump = !(mode3 || mode5);
      cpsr_pkg::JC_GZERO:  jump = (rhs == '0);
      cpsr_pkg::JC_MODE5:  jump = !mode3;
      cpsr_pkg::JC_NEBIT:  jump = !expo[bit_idx];
      cpsr_pkg::JC_KNZ:    jump = (bit_idx != '0);
      cpsr_pkg::JC_TEQG:   jump = (tmp == rhs);
      cpsr_pkg::JC_ZONE:   jump = (zval == cpsr_pkg::FIELD_W'(1));
      cpsr_pkg::JC_NZNEG:  jump = (zval != prime_p - cpsr_pkg::FIELD_W'(1));
      default:             jump = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    pc_next = pc;
    wr_en = 1'b0;
    wr_dst = uc.dst;
    wr_data = opa;
    ld_e = 1'b0;
    dec_k = 1'b0;
    out_load = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a = opa;
    mul_req.b = opb;
    unique case (state)
      cpsr_pkg::SEQ_IDLE: begin
        if (in_valid) begin
          state_next = cpsr_pkg::SEQ_STEP;
          pc_next = cpsr_pkg::L_START;
        end
      end
      cpsr_pkg::SEQ_STEP: begin
        pc_next = jump ? uc.target : pc + 1'b1;
        unique case (uc.op)
          cpsr_pkg::OP_NOP: begin
          end
          cpsr_pkg::OP_MUL: begin
            mul_req.start = 1'b1;
            state_next = cpsr_pkg::SEQ_WAIT;
            pc_next = pc;
          end
          cpsr_pkg::OP_ADD: begin
            wr_en = 1'b1;
            wr_data = add_res;
          end
          cpsr_pkg::OP_MOV: wr_en = 1'b1;
          cpsr_pkg::OP_LDE: ld_e = 1'b1;
          cpsr_pkg::OP_DECK: dec_k = 1'b1;
          cpsr_pkg::OP_FIN_ROOT, cpsr_pkg::OP_FIN_ZERO, cpsr_pkg::OP_FIN_NONE,
          cpsr_pkg::OP_FIN_FAIL: begin
            pc_next = pc;
            if (out_free) begin
              out_load = 1'b1;
              state_next = cpsr_pkg::SEQ_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      cpsr_pkg::SEQ_WAIT: begin
        wr_data = mul_rsp.prod;
        if (mul_rsp.done) begin
          wr_en = 1'b1;
          state_next = cpsr_pkg::SEQ_STEP;
          pc_next = pc + 1'b1;
        end
      end
      default: state_next = cpsr_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpsr_pkg::SEQ_IDLE;
      pc <= cpsr_pkg::L_START;
    end else begin
      state <= state_next;
      pc <= pc_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_hold <= x_coord;
    end
    if (ld_e) begin
      expo <= opa;
      bit_idx <= cpsr_pkg::K_W'(cpsr_pkg::FIELD_W - 1);
      acc <= cpsr_pkg::FIELD_W'(1);
    end else if (dec_k) begin
      bit_idx <= bit_idx - 1'b1;
    end
    if (wr_en) begin
      unique case (wr_dst)
        cpsr_pkg::RG_X:    x_mod <= wr_data;
        cpsr_pkg::RG_G:    rhs <= wr_data;
        cpsr_pkg::RG_T:    tmp <= wr_data;
        cpsr_pkg::RG_C:    aux <= wr_data;
        cpsr_pkg::RG_ACC:  acc <= wr_data;
        cpsr_pkg::RG_BASE: base <= wr_data;
        cpsr_pkg::RG_Y:    root <= wr_data;
        cpsr_pkg::RG_Z:    zval <= wr_data;
        default: begin
        end
      endcase
    end
  end

  cpsr_modmul u_modmul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .modulus (prime_p),
    .rsp     (mul_rsp)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      unique case (uc.op)
        cpsr_pkg::OP_FIN_ROOT: begin
          root_count <= 2'd2;
          y_first <= root;
          y_second <= prime_p - root;
          status <= 1'b0;
        end
        cpsr_pkg::OP_FIN_ZERO: begin
          root_count <= 2'd1;
          y_first <= '0;
          y_second <= '0;
          status <= 1'b0;
        end
        cpsr_pkg::OP_FIN_FAIL: begin
          root_count <= 2'd0;
          y_first <= '0;
          y_second <= '0;
          status <= 1'b1;
        end
        default: begin
          root_count <= 2'd0;
          y_first <= '0;
          y_second <= '0;
          status <= 1'b0;
        end
      endcase
    end
  end

  `CPSR_ASSERT_NXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)
  `CPSR_ASSERT_IMP(a_fail_no_root, clk, rst, out_valid && status, root_count == 2'd0)
  `CPSR_ASSERT_IMP(a_count_range, clk, rst, out_valid, root_count != 2'd3)
  `CPSR_ASSERT_IMP(a_mul_idle_start, clk, rst, mul_req.start, !mul_rsp.busy)

endmodule

`default_nettype wire
